// ----- sv/pid_antiwindup_motor_drive_top_assert.svh -----
// Assertion macros used by the checker of the PID motor drive block.
`ifndef PID_ANTIWINDUP_MOTOR_DRIVE_TOP_ASSERT_SVH
`define PID_ANTIWINDUP_MOTOR_DRIVE_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define PIDAW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PIDAW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/pidaw_pkg.sv -----
// Shared widths, register indexes, constants and types of the PID motor drive block.
`default_nettype none

package pidaw_pkg;

   localparam int ANGLE_W    = 16;
   localparam int ERR_W      = 17;
   localparam int DIFF_W     = 18;
   localparam int SUM_W      = 32;
   localparam int GAIN_W     = 32;
   localparam int LIMIT_W    = 31;
   localparam int TOP_W      = 16;
   localparam int DRIVE_W    = 11;
   localparam int DUTY_W     = 10;
   localparam int FRAC_BITS  = 24;
   localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
   localparam int PROD_D_W   = GAIN_W + 1 + DIFF_W;
   localparam int PROD_I_W   = GAIN_W + 1 + SUM_W;
   localparam int ACC_W      = 55;
   localparam int I_CAP_SHIFT = 52;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_ANGLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_TOP     = 3'd5;

   localparam logic signed [ANGLE_W-1:0] TARGET_ANGLE_RESET = 16'sd102;
   localparam logic [GAIN_W-1:0]         PROP_GAIN_RESET    = 32'd9830400;
   localparam logic [LIMIT_W-1:0]        INTEG_LIMIT_RESET  = 31'd255744000;
   localparam logic [TOP_W-1:0]          DUTY_TOP_RESET     = 16'd999;

   localparam logic [DUTY_W-1:0]         OUT_LIMIT   = 10'd999;
   localparam logic signed [ACC_W-1:0]   OUT_LIMIT_Q = ACC_W'(64'd999 << FRAC_BITS);
   localparam logic signed [PROD_I_W-1:0] I_TERM_CAP = PROD_I_W'(64'd1 << I_CAP_SHIFT);

   typedef struct packed {
      logic signed [ANGLE_W-1:0] target_angle;
      logic [GAIN_W-1:0]         prop_gain;
      logic [GAIN_W-1:0]         integ_gain_scaled;
      logic [GAIN_W-1:0]         deriv_gain_scaled;
      logic [LIMIT_W-1:0]        integ_limit;
      logic [TOP_W-1:0]          duty_top;
   } cfg_type;

   typedef struct packed {
      logic signed [PROD_P_W-1:0] p;
      logic signed [PROD_D_W-1:0] d;
      logic signed [PROD_I_W-1:0] i;
   } prod_type;

endpackage

`default_nettype wire

// ----- sv/pidaw_integrator.sv -----
// Error stage: forms the error, updates the error sum with anti-windup and the error difference.
`default_nettype none

module pidaw_integrator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            load,
   input  wire logic signed [pidaw_pkg::ANGLE_W-1:0] angle,
   input  wire pidaw_pkg::cfg_type              cfg,
   output logic signed [pidaw_pkg::ERR_W-1:0]   err,
   output logic signed [pidaw_pkg::DIFF_W-1:0]  diff,
   output logic signed [pidaw_pkg::SUM_W-1:0]   sum
);
   import pidaw_pkg::*;

   localparam int WIDE_W = SUM_W + 2;
   localparam logic signed [WIDE_W-1:0] SUM_MAX = WIDE_W'(64'h7FFF_FFFF);
   localparam logic signed [WIDE_W-1:0] SUM_MIN = -WIDE_W'(64'h8000_0000);

   logic signed [SUM_W-1:0]  error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]  last_error_ff, last_error_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;

   logic signed [WIDE_W-1:0] lim_pos, lim_neg, sum_ext, err_ext, base, addend, total;

   always_comb begin
      last_error_in = $signed({cfg.target_angle[ANGLE_W-1], cfg.target_angle})
                    - $signed({angle[ANGLE_W-1], angle});
      diff_in = $signed({last_error_in[ERR_W-1], last_error_in})
              - $signed({last_error_ff[ERR_W-1], last_error_ff});

      lim_pos = $signed({{(WIDE_W-LIMIT_W){1'b0}}, cfg.integ_limit});
      lim_neg = -lim_pos;
      sum_ext = $signed({{(WIDE_W-SUM_W){error_sum_ff[SUM_W-1]}}, error_sum_ff});
      err_ext = $signed({{(WIDE_W-ERR_W){last_error_in[ERR_W-1]}}, last_error_in});

      // Above +limit the sum is pinned and may only fall; below -limit it is pinned and may only rise.
      if (sum_ext > lim_pos) begin
         base   = lim_pos;
         addend = last_error_in[ERR_W-1] ? err_ext : '0;
      end else if (sum_ext < lim_neg) begin
         base   = lim_neg;
         addend = (!last_error_in[ERR_W-1] && last_error_in != '0) ? err_ext : '0;
      end else begin
         base   = sum_ext;
         addend = err_ext;
      end
      total = base + addend;

      if (total > SUM_MAX) begin
         error_sum_in = SUM_MAX[SUM_W-1:0];
      end else if (total < SUM_MIN) begin
         error_sum_in = SUM_MIN[SUM_W-1:0];
      end else begin
         error_sum_in = total[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (load) begin
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff <= diff_in;
      end
   end

   // The state registers double as this stage's output register.
   assign err  = last_error_ff;
   assign sum  = error_sum_ff;
   assign diff = diff_ff;

endmodule

`default_nettype wire

// ----- sv/pidaw_multiply.sv -----
// Product stage: the three gain multiplications, registered.
`default_nettype none

module pidaw_multiply (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic signed [pidaw_pkg::ERR_W-1:0]  err,
   input  wire logic signed [pidaw_pkg::DIFF_W-1:0] diff,
   input  wire logic signed [pidaw_pkg::SUM_W-1:0]  sum,
   input  wire pidaw_pkg::cfg_type             cfg,
   output pidaw_pkg::prod_type                 prod
);
   import pidaw_pkg::*;

   prod_type prod_ff, prod_in;

   always_comb begin
      prod_in.p = $signed({1'b0, cfg.prop_gain}) * err;
      prod_in.d = $signed({1'b0, cfg.deriv_gain_scaled}) * diff;
      prod_in.i = $signed({1'b0, cfg.integ_gain_scaled}) * sum;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- sv/pidaw_shaper.sv -----
// Sum and output stages: caps the integral term, adds the terms, clamps and splits the drive.
`default_nettype none

module pidaw_shaper (
   input  wire logic                              clock,
   input  wire logic                              load_sum,
   input  wire logic                              load_out,
   input  wire pidaw_pkg::prod_type               prod,
   input  wire logic [pidaw_pkg::TOP_W-1:0]       duty_top,
   output logic signed [pidaw_pkg::DRIVE_W-1:0]   signed_drive,
   output logic                                   forward_dir,
   output logic [pidaw_pkg::DUTY_W-1:0]           duty
);
   import pidaw_pkg::*;

   logic signed [PROD_I_W-1:0] i_capped;
   logic signed [ACC_W-1:0]    total_ff, total_in;
   logic signed [ACC_W-1:0]    total_mag;
   logic [DUTY_W-1:0]          mag;
   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;
   logic                       dir_ff, dir_in;
   logic [DUTY_W-1:0]          duty_ff, duty_in;

   always_comb begin
      if (prod.i > I_TERM_CAP) begin
         i_capped = I_TERM_CAP;
      end else if (prod.i < -I_TERM_CAP) begin
         i_capped = -I_TERM_CAP;
      end else begin
         i_capped = prod.i;
      end
      total_in = ACC_W'(prod.p) + ACC_W'(prod.d) + ACC_W'(i_capped);
   end

   always_ff @(posedge clock) begin
      if (load_sum) begin
         total_ff <= total_in;
      end
   end

   always_comb begin
      total_mag = total_ff[ACC_W-1] ? -total_ff : total_ff;
      // Truncation is toward zero, so a small negative value gives zero drive.
      if (total_ff > OUT_LIMIT_Q) begin
         mag = OUT_LIMIT;
      end else if (total_ff < -OUT_LIMIT_Q) begin
         mag = OUT_LIMIT;
      end else begin
         mag = total_mag[FRAC_BITS +: DUTY_W];
      end
      drive_in = total_ff[ACC_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      dir_in   = !total_ff[ACC_W-1];
      duty_in  = ({{(TOP_W-DUTY_W){1'b0}}, mag} > duty_top) ? duty_top[DUTY_W-1:0] : mag;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         drive_ff <= drive_in;
         dir_ff   <= dir_in;
         duty_ff  <= duty_in;
      end
   end

   assign signed_drive = drive_ff;
   assign forward_dir  = dir_ff;
   assign duty         = duty_ff;

endmodule

`default_nettype wire

// ----- sv/pid_antiwindup_motor_drive_top.sv -----
// Top level of the PID motor drive block: configuration registers and pipeline control.
`default_nettype none

// PID angle controller with conditional anti-windup. Each request carries a measured angle
// (signed Q7.8); the block returns one drive value clamped to +-999, a direction bit and a
// PWM duty value limited to duty_top. It is a five-register pipeline (input, error and
// error sum, gain products, term sum, output); one request can be taken in every cycle while
// the response is not stalled. Each stage moves on once the stage after it has room, so
// requests keep flowing while a result waits at the output until the stages fill. The error
// sum and previous error are updated when a request leaves the input register. The user
// must write configuration through the csr_ port while no request is in flight (unenforced).

module pid_antiwindup_motor_drive_top (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic signed [pidaw_pkg::ANGLE_W-1:0]    req_measured_angle,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed [pidaw_pkg::DRIVE_W-1:0]         rsp_signed_drive,
   output logic                                         rsp_forward_dir,
   output logic [pidaw_pkg::DUTY_W-1:0]                 rsp_duty,
   input  wire logic                                    csr_we,
   input  wire logic [pidaw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [pidaw_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import pidaw_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic out_valid_ff, out_valid_in;
   logic signed [ANGLE_W-1:0] angle_ff;

   logic ready_out, ready3, ready2, ready1, ready0;
   logic adv0, adv1, adv2, adv3, accept;

   logic signed [ERR_W-1:0]  err;
   logic signed [DIFF_W-1:0] diff;
   logic signed [SUM_W-1:0]  sum;
   prod_type                 prod;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_ANGLE: cfg_in.target_angle      = csr_wdata[ANGLE_W-1:0];
            REG_PROP_GAIN:    cfg_in.prop_gain         = csr_wdata[GAIN_W-1:0];
            REG_INTEG_GAIN:   cfg_in.integ_gain_scaled = csr_wdata[GAIN_W-1:0];
            REG_DERIV_GAIN:   cfg_in.deriv_gain_scaled = csr_wdata[GAIN_W-1:0];
            REG_INTEG_LIMIT:  cfg_in.integ_limit       = csr_wdata[LIMIT_W-1:0];
            REG_DUTY_TOP:     cfg_in.duty_top          = csr_wdata[TOP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle      <= TARGET_ANGLE_RESET;
         cfg_ff.prop_gain         <= PROP_GAIN_RESET;
         cfg_ff.integ_gain_scaled <= '0;
         cfg_ff.deriv_gain_scaled <= '0;
         cfg_ff.integ_limit       <= INTEG_LIMIT_RESET;
         cfg_ff.duty_top          <= DUTY_TOP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Each stage may advance when the next one is empty or advancing itself.
   always_comb begin
      ready_out = !out_valid_ff || rsp_ready;
      ready3    = !s3_valid_ff || ready_out;
      ready2    = !s2_valid_ff || ready3;
      ready1    = !s1_valid_ff || ready2;
      ready0    = !s0_valid_ff || ready1;
      adv3      = s3_valid_ff && ready_out;
      adv2      = s2_valid_ff && ready3;
      adv1      = s1_valid_ff && ready2;
      adv0      = s0_valid_ff && ready1;
      accept    = req_valid && ready0;

      s0_valid_in  = accept ? 1'b1 : (adv0 ? 1'b0 : s0_valid_ff);
      s1_valid_in  = adv0   ? 1'b1 : (adv1 ? 1'b0 : s1_valid_ff);
      s2_valid_in  = adv1   ? 1'b1 : (adv2 ? 1'b0 : s2_valid_ff);
      s3_valid_in  = adv2   ? 1'b1 : (adv3 ? 1'b0 : s3_valid_ff);
      out_valid_in = adv3   ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         angle_ff <= req_measured_angle;
      end
   end

   pidaw_integrator u_integrator (
      .clock (clock),
      .reset (reset),
      .load  (adv0),
      .angle (angle_ff),
      .cfg   (cfg_ff),
      .err   (err),
      .diff  (diff),
      .sum   (sum)
   );

   pidaw_multiply u_multiply (
      .clock (clock),
      .load  (adv1),
      .err   (err),
      .diff  (diff),
      .sum   (sum),
      .cfg   (cfg_ff),
      .prod  (prod)
   );

   pidaw_shaper u_shaper (
      .clock        (clock),
      .load_sum     (adv2),
      .load_out     (adv3),
      .prod         (prod),
      .duty_top     (cfg_ff.duty_top),
      .signed_drive (rsp_signed_drive),
      .forward_dir  (rsp_forward_dir),
      .duty         (rsp_duty)
   );

   assign req_ready = ready0;
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ----- sv/pidaw_checker.sv -----
// Port-level checker for the PID motor drive block and its bind to the top level.
`default_nettype none

`include "pid_antiwindup_motor_drive_top_assert.svh"

module pidaw_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [15:0] req_measured_angle,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [10:0] rsp_signed_drive,
   input  wire logic               rsp_forward_dir,
   input  wire logic [9:0]         rsp_duty,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   logic [10:0] drive_abs;

   assign drive_abs = rsp_signed_drive[10] ? -rsp_signed_drive : rsp_signed_drive;

   `PIDAW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_signed_drive) && $stable(rsp_forward_dir) && $stable(rsp_duty), "response changed while stalled")
   `PIDAW_ASSERT_IMPLY(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "response present straight after reset")
   `PIDAW_ASSERT_IMPLY(a_drive_range, clock, reset, rsp_valid, rsp_signed_drive >= -11'sd999 && rsp_signed_drive <= 11'sd999, "drive outside the output clamp")
   `PIDAW_ASSERT_IMPLY(a_dir_matches, clock, reset, rsp_valid && rsp_signed_drive != 11'sd0, rsp_forward_dir == !rsp_signed_drive[10], "direction disagrees with drive sign")
   `PIDAW_ASSERT_IMPLY(a_duty_bound, clock, reset, rsp_valid, {1'b0, rsp_duty} <= drive_abs, "duty exceeds drive magnitude")

endmodule

bind pid_antiwindup_motor_drive_top pidaw_checker u_pidaw_checker (.*);

`default_nettype wire

// ----- test/pid_antiwindup_motor_drive_top_tb.sv -----
// Self-checking testbench for the PID motor drive block with an in-bench controller predictor.
`default_nettype none

module pid_antiwindup_motor_drive_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pidaw_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int BLOCKS_PER_PHASE = 7;
   localparam int SAMPLES_PER_BLOCK = 84;

   // Indexes that address no register; writes to them must leave the set-up untouched.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam logic signed [SUM_W-1:0] SUM_TOP    = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_BOTTOM = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      forward;
      logic [DUTY_W-1:0]         duty;
   } drive_cmd_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      index;
      logic [CSR_DATA_W-1:0]     wdata;
      logic signed [ANGLE_W-1:0] angle;
      logic                      typed;
      drive_cmd_type             cmd;
   } plan_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [ANGLE_W-1:0]    req_measured_angle = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0]    rsp_signed_drive;
   logic                         rsp_forward_dir;
   logic [DUTY_W-1:0]            rsp_duty;
   logic                         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   int                           send_idle_pct = 6;
   int                           recv_idle_pct = 55;
   int                           fails = 0;
   int unsigned                  cycle_count = 0;

   // Controller copy: register set-up, error sum and previous error.
   cfg_type                      ctrl_cfg;
   logic signed [SUM_W-1:0]      ctrl_sum;
   logic signed [ERR_W-1:0]      ctrl_prev_err;

   drive_cmd_type                cmds_due[$];
   plan_row_type                 plan[$];

   pid_antiwindup_motor_drive_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_measured_angle (req_measured_angle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_signed_drive   (rsp_signed_drive),
      .rsp_forward_dir    (rsp_forward_dir),
      .rsp_duty           (rsp_duty),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Gain times a signed quantity, exact, with the magnitude held at the integral term cap.
   function automatic longint capped_product(logic [GAIN_W-1:0] gain, longint x);
      longint unsigned mag;
      longint unsigned prod;
      mag = (x < 0) ? -x : x;
      prod = 64'(gain) * mag;
      if (prod > (64'd1 << I_CAP_SHIFT))
         prod = 64'd1 << I_CAP_SHIFT;
      return (x < 0) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic drive_cmd_type advance_controller(logic signed [ANGLE_W-1:0] angle);
      longint        err;
      longint        lim;
      longint        sum;
      longint        v;
      longint        outlim;
      longint        mag;
      int            drv;
      drive_cmd_type cmd;
      err = longint'($signed(ctrl_cfg.target_angle)) - longint'(angle);
      lim = longint'(ctrl_cfg.integ_limit);
      sum = longint'(ctrl_sum);
      // Once the sum has run past a bound it is pinned there and only an error that
      // pulls it back is added.
      if (sum > lim) begin
         sum = lim;
         if (err < 0)
            sum += err;
      end else if (sum < -lim) begin
         sum = -lim;
         if (err > 0)
            sum += err;
      end else begin
         sum += err;
      end
      if (sum > longint'(SUM_TOP))
         sum = longint'(SUM_TOP);
      if (sum < longint'(SUM_BOTTOM))
         sum = longint'(SUM_BOTTOM);
      ctrl_sum = sum[SUM_W-1:0];

      v = capped_product(ctrl_cfg.prop_gain, err)
          + capped_product(ctrl_cfg.integ_gain_scaled, sum)
          + capped_product(ctrl_cfg.deriv_gain_scaled, err - longint'(ctrl_prev_err));

      outlim = longint'(OUT_LIMIT) << FRAC_BITS;
      if (v > outlim) begin
         drv = int'(OUT_LIMIT);
      end else if (v < -outlim) begin
         drv = -int'(OUT_LIMIT);
      end else begin
         mag = ((v < 0) ? -v : v) >> FRAC_BITS;
         drv = (v < 0) ? -int'(mag) : int'(mag);
      end
      mag = longint'((drv < 0) ? -drv : drv);
      if (mag > longint'(ctrl_cfg.duty_top))
         mag = longint'(ctrl_cfg.duty_top);

      cmd.drive = drv[DRIVE_W-1:0];
      cmd.forward = (v >= 0);
      cmd.duty = mag[DUTY_W-1:0];
      ctrl_prev_err = err[ERR_W-1:0];
      return cmd;
   endfunction

   function automatic void note_csr_write(logic [CSR_IDX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_TARGET_ANGLE: ctrl_cfg.target_angle = data[ANGLE_W-1:0];
         REG_PROP_GAIN: ctrl_cfg.prop_gain = data[GAIN_W-1:0];
         REG_INTEG_GAIN: ctrl_cfg.integ_gain_scaled = data[GAIN_W-1:0];
         REG_DERIV_GAIN: ctrl_cfg.deriv_gain_scaled = data[GAIN_W-1:0];
         REG_INTEG_LIMIT: ctrl_cfg.integ_limit = data[LIMIT_W-1:0];
         REG_DUTY_TOP: ctrl_cfg.duty_top = data[TOP_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic plan_row_type sample_row(logic signed [ANGLE_W-1:0] angle);
      plan_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.angle = angle;
      return r;
   endfunction

   function automatic plan_row_type checked_row(logic signed [ANGLE_W-1:0] angle, int drive,
                                                logic forward, int duty);
      plan_row_type r;
      r = sample_row(angle);
      r.typed = 1'b1;
      r.cmd.drive = DRIVE_W'(drive);
      r.cmd.forward = forward;
      r.cmd.duty = DUTY_W'(duty);
      return r;
   endfunction

   function automatic plan_row_type write_row(logic [CSR_IDX_W-1:0] index,
                                              logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.kind = ROW_WRITE;
      r.index = index;
      r.wdata = data;
      return r;
   endfunction

   task automatic send_angle(input logic signed [ANGLE_W-1:0] angle, input logic typed,
                             input drive_cmd_type typed_cmd);
      drive_cmd_type cmd;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_measured_angle <= angle;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      cmd = advance_controller(angle);
      cmds_due.push_back(typed ? typed_cmd : cmd);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      while (cmds_due.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   // Registers are only written with the pipeline empty.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      note_csr_write(index, data);
   endtask

   // Extremes turn up now and then; otherwise values sit where the output is not always
   // clamped. Upper data bits beyond each register's width are random.
   task automatic randomize_setup;
      logic [31:0] r;
      logic [31:0] val;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: val = 32'h0000_8000;
         1: val = 32'h0000_7FFF;
         default: val = {16'h0, r[15:0]};
      endcase
      write_reg(REG_TARGET_ANGLE, {r[31:16], val[15:0]});

      case ($urandom_range(0, 7))
         0: val = 32'h0;
         1: val = 32'hFFFF_FFFF;
         default: val = $urandom_range(0, 1 << 22);
      endcase
      write_reg(REG_PROP_GAIN, val);

      case ($urandom_range(0, 7))
         0: val = 32'h0;
         1: val = 32'hFFFF_FFFF;
         default: val = $urandom_range(0, 1 << 17);
      endcase
      write_reg(REG_INTEG_GAIN, val);

      case ($urandom_range(0, 7))
         0: val = 32'h0;
         1: val = 32'hFFFF_FFFF;
         default: val = $urandom_range(0, 1 << 23);
      endcase
      write_reg(REG_DERIV_GAIN, val);

      r = $urandom();
      case ($urandom_range(0, 7))
         0: val = 32'h0;
         1: val = 32'h7FFF_FFFF;
         default: val = $urandom_range(0, 1 << 17);
      endcase
      write_reg(REG_INTEG_LIMIT, {r[31], val[30:0]});

      r = $urandom();
      case ($urandom_range(0, 7))
         0: val = 32'h0;
         1: val = 32'h0000_FFFF;
         2: val = 32'd999;
         3: val = $urandom_range(0, 999);
         default: val = {16'h0, r[15:0]};
      endcase
      write_reg(REG_DUTY_TOP, {r[31:16], val[15:0]});

      if ($urandom_range(0, 1))
         write_reg($urandom_range(0, 1) ? REG_SPARE_7 : REG_SPARE_6, $urandom());
   endtask

   task automatic run_block;
      logic signed [ANGLE_W-1:0] bias;
      logic signed [ANGLE_W-1:0] angle;
      bias = 16'($urandom_range(0, 3000));
      if ($urandom_range(0, 1))
         bias = -bias;
      for (int n = 0; n < SAMPLES_PER_BLOCK; n++) begin
         // The bias keeps one sign for half a block so that the sum is pushed toward its bound.
         if (n == SAMPLES_PER_BLOCK / 2)
            bias = -bias;
         if ($urandom_range(0, 4) == 0)
            angle = 16'($urandom());
         else
            angle = ctrl_cfg.target_angle - bias + 16'($urandom_range(0, 1000)) - 16'sd500;
         if ($urandom_range(0, 149) == 0)
            wait_drained();
         send_angle(angle, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      drive_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cmds_due.size() == 0) begin
            $error("response with no request outstanding: signed_drive %0d",
                   rsp_signed_drive);
            fails = fails + 1;
         end else begin
            want = cmds_due.pop_front();
            if (rsp_signed_drive !== want.drive) begin
               $error("signed_drive: expected %0d, got %0d", want.drive, rsp_signed_drive);
               fails = fails + 1;
            end
            if (rsp_forward_dir !== want.forward) begin
               $error("forward_dir: expected %0d, got %0d", want.forward, rsp_forward_dir);
               fails = fails + 1;
            end
            if (rsp_duty !== want.duty) begin
               $error("duty: expected %0d, got %0d", want.duty, rsp_duty);
               fails = fails + 1;
            end
         end
      end
   end

   initial begin
      ctrl_cfg.target_angle = TARGET_ANGLE_RESET;
      ctrl_cfg.prop_gain = PROP_GAIN_RESET;
      ctrl_cfg.integ_gain_scaled = '0;
      ctrl_cfg.deriv_gain_scaled = '0;
      ctrl_cfg.integ_limit = INTEG_LIMIT_RESET;
      ctrl_cfg.duty_top = DUTY_TOP_RESET;
      ctrl_sum = '0;
      ctrl_prev_err = '0;

      plan = '{
         // Reset set-up: proportional gain of 150 only, so the output is 150*e/256.
         checked_row(16'sd102, 0, 1'b1, 0),
         checked_row(-16'sd32768, 999, 1'b1, 999),
         checked_row(16'sd32767, -999, 1'b0, 999),
         // A slightly negative output truncates to zero but still points backwards.
         checked_row(16'sd103, 0, 1'b0, 0),
         checked_row(16'sd101, 0, 1'b1, 0),
         write_row(REG_DUTY_TOP, 32'hABCD_0100),
         checked_row(-16'sd32768, 999, 1'b1, 256),
         write_row(REG_DUTY_TOP, 32'h0),
         write_row(REG_TARGET_ANGLE, 32'hFFFF_8000),
         checked_row(16'sd32767, -999, 1'b0, 0),
         write_row(REG_TARGET_ANGLE, 32'h0000_7FFF),
         checked_row(-16'sd32768, 999, 1'b1, 0),
         write_row(REG_SPARE_6, 32'h0000_0001),
         write_row(REG_SPARE_7, 32'hFFFF_FFFF),
         checked_row(16'sd32767, 0, 1'b1, 0),
         // Integral only, with a small bound: pin above, cross over, pin below.
         write_row(REG_DUTY_TOP, 32'd999),
         write_row(REG_PROP_GAIN, 32'h0),
         write_row(REG_INTEG_GAIN, 32'h0001_0000),
         write_row(REG_INTEG_LIMIT, 32'h8000_0100),
         write_row(REG_TARGET_ANGLE, 32'h0),
         sample_row(-16'sd32768),
         sample_row(-16'sd32768),
         sample_row(16'sd32767),
         sample_row(16'sd32767),
         sample_row(-16'sd100),
         sample_row(16'sd0),
         write_row(REG_INTEG_GAIN, 32'h0),
         write_row(REG_DERIV_GAIN, 32'h0001_0000),
         sample_row(-16'sd1000),
         sample_row(16'sd1000),
         sample_row(16'sd0),
         write_row(REG_PROP_GAIN, 32'hFFFF_FFFF),
         write_row(REG_INTEG_GAIN, 32'hFFFF_FFFF),
         write_row(REG_DERIV_GAIN, 32'hFFFF_FFFF),
         write_row(REG_INTEG_LIMIT, 32'h7FFF_FFFF),
         sample_row(-16'sd32768),
         sample_row(16'sd32767),
         sample_row(16'sd0)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         if (plan[k].kind == ROW_WRITE)
            write_reg(plan[k].index, plan[k].wdata);
         else
            send_angle(plan[k].angle, plan[k].typed, plan[k].cmd);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
            randomize_setup();
            run_block();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fails == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
